// ===== hdl/i2cm_pkg.sv =====
// Shared types, register map, command codes and constants of the I2C master register front end.
package i2cm_pkg;

	localparam int RX_DEPTH_DEF = 256;

	// Item kinds
	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_RXB   = 2'd2;

	// Register byte offsets
	localparam logic [15:0] REG_VERSION = 16'h0000;
	localparam logic [15:0] REG_PARAM   = 16'h0004;
	localparam logic [15:0] REG_CTRL    = 16'h0010;
	localparam logic [15:0] REG_STATUS  = 16'h0014;
	localparam logic [15:0] REG_IEN     = 16'h0018;
	localparam logic [15:0] REG_CFG1    = 16'h0024;
	localparam logic [15:0] REG_FIFOST  = 16'h005C;
	localparam logic [15:0] REG_TXCMD   = 16'h0060;
	localparam logic [15:0] REG_RXDATA  = 16'h0070;

	// Command codes in the transmit data word
	localparam logic [2:0] CMD_SEND  = 3'd0;
	localparam logic [2:0] CMD_RECV  = 3'd1;
	localparam logic [2:0] CMD_STOP  = 3'd2;
	localparam logic [2:0] CMD_START = 3'd4;

	// Requests to the bus engine
	localparam logic [2:0] BUS_NONE  = 3'd0;
	localparam logic [2:0] BUS_START = 3'd1;
	localparam logic [2:0] BUS_SEND  = 3'd2;
	localparam logic [2:0] BUS_RECV  = 3'd3;
	localparam logic [2:0] BUS_STOP  = 3'd4;

	// Register values and bit masks
	localparam logic [31:0] VERSION_VAL  = 32'h0100_0003;
	localparam logic [31:0] PARAM_VAL    = 32'h0000_0303;
	localparam logic [31:0] CTL_EN       = 32'h0000_0001;
	localparam logic [31:0] CTL_MOMENT   = 32'h0000_0302;
	localparam logic [31:0] CTL_RXRST    = 32'h0000_0200;
	localparam logic [31:0] ST_TXRDY     = 32'h0000_0001;
	localparam logic [31:0] ST_RXRDY     = 32'h0000_0002;
	localparam logic [31:0] ST_END       = 32'h0000_0100;
	localparam logic [31:0] ST_STOP      = 32'h0000_0200;
	localparam logic [31:0] ST_NACK      = 32'h0000_0400;
	localparam logic [31:0] ST_CLEARABLE = ST_END | ST_STOP | ST_NACK | (32'hF << 11);
	localparam logic [31:0] ST_BUSY      = (32'h1 << 24) | (32'h1 << 25);
	localparam logic [31:0] RX_EMPTY     = 32'h1 << 14;
	localparam logic [31:0] FILL_MASK    = 32'h0000_007F;

	// Receive queue requests for one beat
	typedef struct packed {
		logic push;
		logic pop;
		logic clr;
	} fifo_ctl_t;

	// Result of one beat, before the popped byte is merged in
	typedef struct packed {
		logic [31:0] read_data;
		logic        irq;
		logic [2:0]  bus_cmd;
		logic [6:0]  bus_addr;
		logic        bus_rw;
		logic [7:0]  bus_tx_byte;
		logic [8:0]  bus_rx_count;
	} result_t;

endpackage

// ===== hdl/i2c_master_command_regs.sv =====
// Top level of the I2C master register front end: decode, receive queue and result stage.
//
//  channel | handshake          | beat payload
//  --------+--------------------+------------------------------------------------------
//  in      | in_valid/in_stall  | op, offset, wdata, bus_nack, rx_byte
//  out     | out_valid/out_stall| read_data, irq, bus_cmd, bus_addr, bus_rw,
//          |                    | bus_tx_byte, bus_rx_count
//
// One beat is accepted per cycle while in_stall is low; its result appears on the out
// channel in the cycle after. The rate is set by the receive queue memory: one write port,
// one registered read port. A stalled result holds in the output stage; the in side stalls
// only while that stage is full and out_stall is high. Reset (arst_n low) clears the
// control state and empties the queue at once; the queue memory needs no clearing pass.
module i2c_master_command_regs
	import i2cm_pkg::*;
#(
	parameter int RX_DEPTH = RX_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [15:0] offset,
	input  logic [31:0] wdata,
	input  logic        bus_nack,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_data,
	output logic        irq,
	output logic [2:0]  bus_cmd,
	output logic [6:0]  bus_addr,
	output logic        bus_rw,
	output logic [7:0]  bus_tx_byte,
	output logic [8:0]  bus_rx_count
);

	localparam int FILL_W = $clog2(RX_DEPTH + 1);

	logic              acc;
	fifo_ctl_t         fifo_ctl;
	result_t           res;
	logic [FILL_W-1:0] fill_q;
	logic              nonempty_nxt;
	logic [7:0]        rdata_q;
	logic              valid_s1;
	logic              pop_s1;
	result_t           res_s1;

	// Stall the input only when a result is waiting and the sink is stalling.
	assign in_stall = valid_s1 && out_stall;
	assign acc      = in_valid && !in_stall;

	i2cm_regs #(
		.RX_DEPTH(RX_DEPTH)
	) u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.acc         (acc),
		.op          (op),
		.offset      (offset),
		.wdata       (wdata),
		.bus_nack    (bus_nack),
		.fill_q      (fill_q),
		.nonempty_nxt(nonempty_nxt),
		.fifo_ctl    (fifo_ctl),
		.res         (res)
	);

	i2cm_rx_fifo #(
		.RX_DEPTH(RX_DEPTH)
	) u_rx_fifo (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (fifo_ctl),
		.rx_byte     (rx_byte),
		.fill_q      (fill_q),
		.nonempty_nxt(nonempty_nxt),
		.rdata_q     (rdata_q)
	);

	// Output stage: advance on accept, drop when taken, hold while stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pop_s1   <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
			pop_s1   <= fifo_ctl.pop;
		end else if (!out_stall) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_s1 <= res;
		end
	end

	// The memory read register loads only on an accepted pop, so it holds with the stage.
	assign out_valid    = valid_s1;
	assign read_data    = pop_s1 ? 32'(rdata_q) : res_s1.read_data;
	assign irq          = res_s1.irq;
	assign bus_cmd      = res_s1.bus_cmd;
	assign bus_addr     = res_s1.bus_addr;
	assign bus_rw       = res_s1.bus_rw;
	assign bus_tx_byte  = res_s1.bus_tx_byte;
	assign bus_rx_count = res_s1.bus_rx_count;

	// Queue never holds more than its depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(RX_DEPTH))
		else $error("receive queue fill above depth");

	// An accepted pop removes exactly one byte.
	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		acc && fifo_ctl.pop |=> fill_q == $past(fill_q) - FILL_W'(1))
		else $error("pop did not decrement fill");

	// A pop is only issued against a nonempty queue.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_ctl.pop |-> fill_q != '0)
		else $error("pop issued on empty queue");

	// Input stall only while a result waits in the output stage.
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_stall)
		else $error("input stalled without a waiting result");

endmodule

// ===== hdl/i2cm_rx_fifo.sv =====
// Receive byte queue: one synchronous memory with a registered read port.
module i2cm_rx_fifo
	import i2cm_pkg::*;
#(
	parameter int RX_DEPTH = RX_DEPTH_DEF,
	localparam int PTR_W = $clog2(RX_DEPTH),
	localparam int FILL_W = $clog2(RX_DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  fifo_ctl_t         ctl,
	input  logic [7:0]        rx_byte,
	output logic [FILL_W-1:0] fill_q,
	output logic              nonempty_nxt,
	output logic [7:0]        rdata_q
);

	logic [7:0]        rx_mem_q [RX_DEPTH];
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [PTR_W:0]    tail_sum;
	logic [PTR_W-1:0]  tail;
	logic              push_ok;
	logic              pop_ok;
	logic [FILL_W-1:0] fill_nxt;

	assign push_ok = ctl.push && (fill_q != FILL_W'(RX_DEPTH));
	assign pop_ok  = ctl.pop && (fill_q != '0);

	// Tail sits fill entries past the head, wrapped once.
	always_comb begin
		tail_sum = (PTR_W + 1)'(rd_ptr_q) + (PTR_W + 1)'(fill_q);
		if (tail_sum >= (PTR_W + 1)'(RX_DEPTH)) begin
			tail_sum = tail_sum - (PTR_W + 1)'(RX_DEPTH);
		end
		tail = tail_sum[PTR_W-1:0];
	end

	always_comb begin
		fill_nxt = fill_q;
		if (ctl.clr) begin
			fill_nxt = '0;
		end else if (push_ok) begin
			fill_nxt = fill_q + FILL_W'(1);
		end else if (pop_ok) begin
			fill_nxt = fill_q - FILL_W'(1);
		end
	end

	assign nonempty_nxt = (fill_nxt != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			rd_ptr_q <= '0;
		end else begin
			fill_q <= fill_nxt;
			if (ctl.clr) begin
				rd_ptr_q <= '0;
			end else if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(RX_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
		end
	end

	// A popped entry was always written at an earlier edge, and a push never
	// lands on the head entry while it holds data, so no bypass is needed.
	always_ff @(posedge clk) begin
		if (push_ok) begin
			rx_mem_q[tail] <= rx_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_ok) begin
			rdata_q <= rx_mem_q[rd_ptr_q];
		end
	end

endmodule

// ===== hdl/i2cm_regs.sv =====
// Control, status, enable and config registers with access and command decode.
module i2cm_regs
	import i2cm_pkg::*;
#(
	parameter int RX_DEPTH = RX_DEPTH_DEF,
	localparam int FILL_W = $clog2(RX_DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              acc,
	input  logic [1:0]        op,
	input  logic [15:0]       offset,
	input  logic [31:0]       wdata,
	input  logic              bus_nack,
	input  logic [FILL_W-1:0] fill_q,
	input  logic              nonempty_nxt,
	output fifo_ctl_t         fifo_ctl,
	output result_t           res
);

	logic [31:0] ctrl_q;
	logic [31:0] sticky_q;
	logic [31:0] ien_q;
	logic [31:0] cfg1_q;
	logic [31:0] ctrl_nxt;
	logic [31:0] sticky_nxt;
	logic [31:0] ien_nxt;
	logic [31:0] cfg1_nxt;
	logic [31:0] status_cur;
	logic [31:0] status_nxt;

	assign status_cur = sticky_q | ST_TXRDY | ((fill_q != '0) ? ST_RXRDY : '0);

	always_comb begin
		ctrl_nxt   = ctrl_q;
		sticky_nxt = sticky_q;
		ien_nxt    = ien_q;
		cfg1_nxt   = cfg1_q;
		fifo_ctl   = '0;
		res        = '0;
		case (op)
			OP_READ: begin
				unique case (offset)
					REG_VERSION: res.read_data = VERSION_VAL;
					REG_PARAM:   res.read_data = PARAM_VAL;
					REG_CTRL:    res.read_data = ctrl_q;
					REG_STATUS:  res.read_data = status_cur;
					REG_IEN:     res.read_data = ien_q;
					REG_CFG1:    res.read_data = cfg1_q;
					REG_FIFOST:  res.read_data = (32'(fill_q) & FILL_MASK) << 16;
					REG_RXDATA: begin
						// Popped byte is merged in one stage later.
						if (fill_q == '0) begin
							res.read_data = RX_EMPTY;
						end else begin
							fifo_ctl.pop = acc;
						end
					end
					default: res.read_data = '0;
				endcase
			end
			OP_WRITE: begin
				unique case (offset)
					REG_CTRL: begin
						fifo_ctl.clr = acc && ((wdata & CTL_RXRST) != '0);
						ctrl_nxt     = wdata & ~CTL_MOMENT;
					end
					REG_STATUS: sticky_nxt = sticky_q & ~(wdata & ST_CLEARABLE);
					REG_IEN:    ien_nxt = wdata;
					REG_CFG1:   cfg1_nxt = wdata;
					REG_TXCMD: begin
						if ((ctrl_q & CTL_EN) != '0) begin
							unique case (wdata[10:8])
								CMD_START: begin
									res.bus_cmd  = BUS_START;
									res.bus_addr = wdata[7:1];
									res.bus_rw   = wdata[0];
									sticky_nxt   = sticky_q | (bus_nack ? ST_NACK : ST_BUSY);
								end
								CMD_SEND: begin
									res.bus_cmd     = BUS_SEND;
									res.bus_tx_byte = wdata[7:0];
									if (bus_nack) begin
										sticky_nxt = sticky_q | ST_NACK;
									end
								end
								CMD_RECV: begin
									res.bus_cmd      = BUS_RECV;
									res.bus_rx_count = {1'b0, wdata[7:0]} + 9'd1;
								end
								CMD_STOP: begin
									res.bus_cmd = BUS_STOP;
									sticky_nxt  = (sticky_q | ST_STOP | ST_END) & ~ST_BUSY;
								end
								default: res.bus_cmd = BUS_NONE;
							endcase
						end
					end
					default: ;
				endcase
			end
			OP_RXB: fifo_ctl.push = acc;
			default: ;
		endcase
		status_nxt = sticky_nxt | ST_TXRDY | (nonempty_nxt ? ST_RXRDY : '0);
		res.irq    = ((status_nxt & ien_nxt) != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q   <= '0;
			sticky_q <= '0;
			ien_q    <= '0;
			cfg1_q   <= '0;
		end else if (acc) begin
			ctrl_q   <= ctrl_nxt;
			sticky_q <= sticky_nxt;
			ien_q    <= ien_nxt;
			cfg1_q   <= cfg1_nxt;
		end
	end

endmodule
